/* rtl/ylc_pkg.sv */
// Shared types, constants and helper functions of the luma adjust pixel core.
package ylc_pkg;

   // Fixed-point format of the color matrix coefficients.
   localparam int COEF_FRAC_BITS = 14;
   localparam int COEF_W         = COEF_FRAC_BITS + 2;
   localparam int FPROD_W        = 8 + COEF_W;
   localparam int SUM_W          = COEF_FRAC_BITS + 12;
   localparam int IPROD_W        = 9 + COEF_W + 1;
   localparam int GAIN_W         = 9;
   localparam int GPROD_W        = 8 + GAIN_W;

   // Register port.
   localparam int ADDR_W = 3;
   localparam int DATA_W = 32;

   // Queue between front and back.
   localparam int Q_DEPTH = 4;
   localparam int Q_PTR_W = $clog2(Q_DEPTH);
   localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

   // Rounds a four-decimal coefficient magnitude to the fixed-point grid.
   function automatic longint qcoef(longint c4);
      return ((c4 <<< COEF_FRAC_BITS) + 64'sd5000) / 64'sd10000;
   endfunction

   // Forward matrix magnitudes, rows Y, Cb, Cr and columns B, G, R.
   localparam logic [COEF_W-1:0] FWD_COEF [3][3] = '{
      '{COEF_W'(qcoef(1140)), COEF_W'(qcoef(5870)), COEF_W'(qcoef(2990))},
      '{COEF_W'(qcoef(5000)), COEF_W'(qcoef(3313)), COEF_W'(qcoef(1687))},
      '{COEF_W'(qcoef(813)),  COEF_W'(qcoef(4187)), COEF_W'(qcoef(5000))}
   };

   // Inverse matrix magnitudes.
   localparam logic [COEF_W-1:0] K_R_CR = COEF_W'(qcoef(14020));
   localparam logic [COEF_W-1:0] K_G_CB = COEF_W'(qcoef(3441));
   localparam logic [COEF_W-1:0] K_G_CR = COEF_W'(qcoef(7139));
   localparam logic [COEF_W-1:0] K_B_CB = COEF_W'(qcoef(17718));

   localparam logic signed [SUM_W-1:0] CHROMA_OFS = SUM_W'(longint'(128) <<< COEF_FRAC_BITS);

   localparam logic [1:0]      MODE_RESET = 2'd3;
   localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(179);

   typedef enum logic [1:0] {
      MODE_TO_YCC = 2'd0,
      MODE_LUMA   = 2'd1,
      MODE_TO_BGR = 2'd2,
      MODE_ROUND  = 2'd3
   } mode_type;

   typedef enum logic {
      REG_MODE = 1'b0,
      REG_GAIN = 1'b1
   } reg_index_type;

   typedef struct packed {
      mode_type          mode;
      logic [GAIN_W-1:0] luma_gain;
   } cfg_type;

   // Which of the three processing steps a word goes through.
   typedef struct packed {
      logic fwd;
      logic gain;
      logic inv;
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [7:0] ch0;
      logic [7:0] ch1;
      logic [7:0] ch2;
   } item_type;

   // Drops the fraction bits of a signed sum, truncating toward zero, and
   // clamps the result to 0..255.
   function automatic logic [7:0] sat8(logic signed [SUM_W-1:0] v);
      logic signed [SUM_W-1:0] q;
      logic [7:0]              r;
      q = v >>> COEF_FRAC_BITS;
      if (v[SUM_W-1]) begin
         r = 8'd0;
      end else if (|q[SUM_W-1:8]) begin
         r = 8'hFF;
      end else begin
         r = q[7:0];
      end
      return r;
   endfunction

endpackage

/* rtl/ylc_csr.sv */
// Configuration registers of the luma adjust pixel core behind an APB-style port.
module ylc_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [ylc_pkg::ADDR_W-1:0] paddr,
   input  logic [ylc_pkg::DATA_W-1:0] pwdata,
   output logic [ylc_pkg::DATA_W-1:0] prdata,
   output logic                        pready,
   output ylc_pkg::cfg_type            cfg
);
   import ylc_pkg::*;

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type idx;
   logic          wr;

   assign pready = 1'b1;
   assign idx    = reg_index_type'(paddr[2]);
   assign wr     = psel && penable && pwrite && pready;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         case (idx)
            REG_MODE: cfg_in.mode      = mode_type'(pwdata[1:0]);
            REG_GAIN: cfg_in.luma_gain = pwdata[GAIN_W-1:0];
            default:  cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (idx)
         REG_MODE: prdata = DATA_W'(cfg_ff.mode);
         REG_GAIN: prdata = DATA_W'(cfg_ff.luma_gain);
         default:  prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode      <= mode_type'(MODE_RESET);
         cfg_ff.luma_gain <= GAIN_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

/* rtl/ylc_front.sv */
// Input stage: takes pixel words and tags each with the steps its mode calls for.
module ylc_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [7:0]        req_in_ch0,
   input  logic [7:0]        req_in_ch1,
   input  logic [7:0]        req_in_ch2,
   input  ylc_pkg::mode_type mode,
   output logic              item_valid,
   input  logic              item_ready,
   output ylc_pkg::item_type item
);
   import ylc_pkg::*;

   logic     f_valid_ff;
   logic     f_valid_in;
   item_type f_item_ff;
   item_type f_item_in;
   op_type   op;
   logic     accept;

   // The round trip runs all three steps; the other modes run one.
   always_comb begin
      op = '0;
      case (mode)
         MODE_TO_YCC: op.fwd = 1'b1;
         MODE_LUMA:   op.gain = 1'b1;
         MODE_TO_BGR: op.inv = 1'b1;
         MODE_ROUND: begin
            op.fwd  = 1'b1;
            op.gain = 1'b1;
            op.inv  = 1'b1;
         end
         default:     op = '0;
      endcase
   end

   assign req_ready  = !f_valid_ff || item_ready;
   assign accept     = req_valid && req_ready;
   assign item_valid = f_valid_ff;
   assign item       = f_item_ff;

   always_comb begin
      f_valid_in = f_valid_ff && !item_ready;
      f_item_in  = f_item_ff;
      if (accept) begin
         f_valid_in    = 1'b1;
         f_item_in.op  = op;
         f_item_in.ch0 = req_in_ch0;
         f_item_in.ch1 = req_in_ch1;
         f_item_in.ch2 = req_in_ch2;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
      end else begin
         f_valid_ff <= f_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      f_item_ff <= f_item_in;
   end

endmodule

/* rtl/ylc_queue.sv */
// Small first-in first-out queue of tagged words between front and back.
module ylc_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  ylc_pkg::item_type in_item,
   output logic              out_valid,
   input  logic              out_ready,
   output ylc_pkg::item_type out_item
);
   import ylc_pkg::*;

   item_type             slot_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]   wr_ptr_ff;
   logic [Q_PTR_W-1:0]   wr_ptr_in;
   logic [Q_PTR_W-1:0]   rd_ptr_ff;
   logic [Q_PTR_W-1:0]   rd_ptr_in;
   logic [Q_CNT_W-1:0]   cnt_ff;
   logic [Q_CNT_W-1:0]   cnt_in;
   logic                 push;
   logic                 pop;

   assign in_ready  = cnt_ff != Q_CNT_W'(Q_DEPTH);
   assign out_valid = cnt_ff != '0;
   assign out_item  = slot_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_item;
      end
   end

`ifndef SYNTHESIS
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= Q_CNT_W'(Q_DEPTH))
      else $error("queue count above depth");

   a_cnt_grow: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (cnt_ff == $past(cnt_ff) + 1'b1))
      else $error("queue count did not follow a push");

   a_empty_ptr: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == '0) |-> (rd_ptr_ff == wr_ptr_ff))
      else $error("empty queue with pointers apart");
`endif

endmodule

/* rtl/ylc_back.sv */
// Six-stage color arithmetic pipeline: forward matrix, luma gain, inverse matrix.
module ylc_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  ylc_pkg::item_type           in_item,
   input  logic [ylc_pkg::GAIN_W-1:0]  luma_gain,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [7:0]                  rsp_out_ch0,
   output logic [7:0]                  rsp_out_ch1,
   output logic [7:0]                  rsp_out_ch2
);
   import ylc_pkg::*;

   localparam int STAGES = 6;

   logic [STAGES-1:0] v_ff;
   logic [STAGES-1:0] v_in;
   logic              adv;

   // Stage 1: forward products and the raw pixel.
   op_type             s1_op_ff, s1_op_in;
   logic [7:0]         s1_pix_ff [3];
   logic [7:0]         s1_pix_in [3];
   logic [FPROD_W-1:0] s1_fp_ff [3][3];
   logic [FPROD_W-1:0] s1_fp_in [3][3];

   // Stage 2: Y, Cb, Cr.
   op_type     s2_op_ff, s2_op_in;
   logic [7:0] s2_y_ff, s2_y_in, s2_cb_ff, s2_cb_in, s2_cr_ff, s2_cr_in;
   logic signed [SUM_W-1:0] fe [3][3];
   logic signed [SUM_W-1:0] sum_y, sum_cb, sum_cr;

   // Stage 3: luma product.
   op_type             s3_op_ff, s3_op_in;
   logic [GPROD_W-1:0] s3_gp_ff, s3_gp_in;
   logic [7:0] s3_y_ff, s3_y_in, s3_cb_ff, s3_cb_in, s3_cr_ff, s3_cr_in;

   // Stage 4: scaled luma.
   op_type     s4_op_ff, s4_op_in;
   logic [7:0] s4_y_ff, s4_y_in, s4_cb_ff, s4_cb_in, s4_cr_ff, s4_cr_in;
   logic [GPROD_W-9:0] scaled;

   // Stage 5: inverse products.
   op_type     s5_op_ff, s5_op_in;
   logic [7:0] s5_y_ff, s5_y_in, s5_cb_ff, s5_cb_in, s5_cr_ff, s5_cr_in;
   logic signed [IPROD_W-1:0] s5_r_cr_ff, s5_r_cr_in, s5_g_cb_ff, s5_g_cb_in;
   logic signed [IPROD_W-1:0] s5_g_cr_ff, s5_g_cr_in, s5_b_cb_ff, s5_b_cb_in;
   logic signed [8:0] cbd, crd;

   // Stage 6: result word.
   logic [7:0] s6_o0_ff, s6_o0_in, s6_o1_ff, s6_o1_in, s6_o2_ff, s6_o2_in;
   logic signed [SUM_W-1:0] yq;

   // The whole pipe moves when the result register is free or being taken.
   assign adv       = !v_ff[STAGES-1] || rsp_ready;
   assign in_ready  = adv;
   assign v_in      = adv ? {v_ff[STAGES-2:0], in_valid} : v_ff;
   assign rsp_valid = v_ff[STAGES-1];
   assign rsp_out_ch0 = s6_o0_ff;
   assign rsp_out_ch1 = s6_o1_ff;
   assign rsp_out_ch2 = s6_o2_ff;

   always_comb begin
      s1_op_in     = in_item.op;
      s1_pix_in[0] = in_item.ch0;
      s1_pix_in[1] = in_item.ch1;
      s1_pix_in[2] = in_item.ch2;
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            s1_fp_in[r][c] = FPROD_W'(s1_pix_in[c]) * FPROD_W'(FWD_COEF[r][c]);
         end
      end
   end

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            fe[r][c] = $signed(SUM_W'(s1_fp_ff[r][c]));
         end
      end
      sum_y    = fe[0][0] + fe[0][1] + fe[0][2];
      sum_cb   = fe[1][0] - fe[1][1] - fe[1][2] + CHROMA_OFS;
      sum_cr   = fe[2][2] - fe[2][0] - fe[2][1] + CHROMA_OFS;
      s2_op_in = s1_op_ff;
      s2_y_in  = s1_op_ff.fwd ? sat8(sum_y)  : s1_pix_ff[0];
      s2_cb_in = s1_op_ff.fwd ? sat8(sum_cb) : s1_pix_ff[1];
      s2_cr_in = s1_op_ff.fwd ? sat8(sum_cr) : s1_pix_ff[2];
   end

   always_comb begin
      s3_op_in = s2_op_ff;
      s3_gp_in = GPROD_W'(s2_y_ff) * GPROD_W'(luma_gain);
      s3_y_in  = s2_y_ff;
      s3_cb_in = s2_cb_ff;
      s3_cr_in = s2_cr_ff;
   end

   always_comb begin
      scaled   = s3_gp_ff[GPROD_W-1:8];
      s4_op_in = s3_op_ff;
      s4_cb_in = s3_cb_ff;
      s4_cr_in = s3_cr_ff;
      if (s3_op_ff.gain) begin
         s4_y_in = (|scaled[GPROD_W-9:8]) ? 8'hFF : scaled[7:0];
      end else begin
         s4_y_in = s3_y_ff;
      end
   end

   always_comb begin
      cbd = $signed({1'b0, s4_cb_ff}) - $signed(9'd128);
      crd = $signed({1'b0, s4_cr_ff}) - $signed(9'd128);
      s5_op_in   = s4_op_ff;
      s5_y_in    = s4_y_ff;
      s5_cb_in   = s4_cb_ff;
      s5_cr_in   = s4_cr_ff;
      s5_r_cr_in = IPROD_W'(crd) * IPROD_W'($signed({1'b0, K_R_CR}));
      s5_g_cb_in = IPROD_W'(cbd) * IPROD_W'($signed({1'b0, K_G_CB}));
      s5_g_cr_in = IPROD_W'(crd) * IPROD_W'($signed({1'b0, K_G_CR}));
      s5_b_cb_in = IPROD_W'(cbd) * IPROD_W'($signed({1'b0, K_B_CB}));
   end

   always_comb begin
      yq = $signed(SUM_W'(s5_y_ff) << COEF_FRAC_BITS);
      if (s5_op_ff.inv) begin
         s6_o0_in = sat8(yq + SUM_W'(s5_b_cb_ff));
         s6_o1_in = sat8(yq - SUM_W'(s5_g_cb_ff) - SUM_W'(s5_g_cr_ff));
         s6_o2_in = sat8(yq + SUM_W'(s5_r_cr_ff));
      end else begin
         s6_o0_in = s5_y_ff;
         s6_o1_in = s5_cb_ff;
         s6_o2_in = s5_cr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_op_ff   <= s1_op_in;
         s1_pix_ff  <= s1_pix_in;
         s1_fp_ff   <= s1_fp_in;
         s2_op_ff   <= s2_op_in;
         s2_y_ff    <= s2_y_in;
         s2_cb_ff   <= s2_cb_in;
         s2_cr_ff   <= s2_cr_in;
         s3_op_ff   <= s3_op_in;
         s3_gp_ff   <= s3_gp_in;
         s3_y_ff    <= s3_y_in;
         s3_cb_ff   <= s3_cb_in;
         s3_cr_ff   <= s3_cr_in;
         s4_op_ff   <= s4_op_in;
         s4_y_ff    <= s4_y_in;
         s4_cb_ff   <= s4_cb_in;
         s4_cr_ff   <= s4_cr_in;
         s5_op_ff   <= s5_op_in;
         s5_y_ff    <= s5_y_in;
         s5_cb_ff   <= s5_cb_in;
         s5_cr_ff   <= s5_cr_in;
         s5_r_cr_ff <= s5_r_cr_in;
         s5_g_cb_ff <= s5_g_cb_in;
         s5_g_cr_ff <= s5_g_cr_in;
         s5_b_cb_ff <= s5_b_cb_in;
         s6_o0_ff   <= s6_o0_in;
         s6_o1_ff   <= s6_o1_in;
         s6_o2_ff   <= s6_o2_in;
      end
   end

`ifndef SYNTHESIS
   a_hold: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(v_ff))
      else $error("pipeline valid bits moved while stalled");

   a_advance: assert property (@(posedge clock) disable iff (reset)
      (adv && v_ff[0]) |=> v_ff[1])
      else $error("word lost between first and second stage");
`endif

endmodule

/* rtl/ycbcr_luma_adjust_pixel_core.sv */
// Top level of the BT.601 full-range color converter with luma gain.
//
//   Channel   Ports                          Direction  Moves
//   req       req_valid/req_ready, req_in_*  in         one pixel word
//   rsp       rsp_valid/rsp_ready, rsp_out_* out        one pixel word
//   csr       psel/penable/pwrite/paddr/...  in/out     mode (0x0), luma_gain (0x4)
//
// Sustained rate is one word per clock cycle in every mode while rsp is ready;
// back stages 1, 3 and 5 form products, 2 and 6 add and clamp, 4 clamps the gain.
// With the result side ready, an accepted word passes the front register, a
// queue slot and the six back stages, the sixth being the result register on rsp.
// Reset clears all valid bits and the queue, and loads mode 3 and gain 179.
// A stall on rsp freezes the back pipeline; the four-word queue and the front
// register keep taking words until they fill, then req_ready drops.
module ycbcr_luma_adjust_pixel_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [7:0]                  req_in_ch0,
   input  logic [7:0]                  req_in_ch1,
   input  logic [7:0]                  req_in_ch2,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [7:0]                  rsp_out_ch0,
   output logic [7:0]                  rsp_out_ch1,
   output logic [7:0]                  rsp_out_ch2,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [ylc_pkg::ADDR_W-1:0] paddr,
   input  logic [ylc_pkg::DATA_W-1:0] pwdata,
   output logic [ylc_pkg::DATA_W-1:0] prdata,
   output logic                        pready
);
   import ylc_pkg::*;

   cfg_type  cfg;
   logic     f_valid;
   logic     f_ready;
   item_type f_item;
   logic     q_valid;
   logic     q_ready;
   item_type q_item;

   // Register file. The mode is sampled when a word enters, the gain when the word
   // reaches the luma stage; write both only while idle, the block does not check.
   ylc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // Front: accepts a pixel and tags it with the steps its mode needs.
   ylc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_in_ch0 (req_in_ch0),
      .req_in_ch1 (req_in_ch1),
      .req_in_ch2 (req_in_ch2),
      .mode       (cfg.mode),
      .item_valid (f_valid),
      .item_ready (f_ready),
      .item       (f_item)
   );

   // The queue lets the front keep accepting while the back is stalled.
   ylc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .in_item   (f_item),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_item  (q_item)
   );

   // Back: forward matrix, luma gain and inverse matrix, each skipped by
   // passing the channels through when the word's tag does not ask for it.
   ylc_back u_back (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (q_valid),
      .in_ready    (q_ready),
      .in_item     (q_item),
      .luma_gain   (cfg.luma_gain),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_out_ch0 (rsp_out_ch0),
      .rsp_out_ch1 (rsp_out_ch1),
      .rsp_out_ch2 (rsp_out_ch2)
   );

endmodule
